// ----- rtl/range_allocator_first_fit_core_macros.svh -----
// ----------------------------------------------------------------------------
// range allocator assertion macros
// shared concurrent assertion forms, clocked on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef RANGE_ALLOCATOR_FIRST_FIT_CORE_MACROS_SVH
`define RANGE_ALLOCATOR_FIRST_FIT_CORE_MACROS_SVH

// same-cycle implication
`define RAFF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RAFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/raff_pkg.sv -----
// ----------------------------------------------------------------------------
// raff_pkg
// types, codes and helpers of the first-fit range allocator
// ----------------------------------------------------------------------------
package raff_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic [31:0]      word_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    word_t e;
    word_t s;
  } entry_t;

  localparam cnt_t  CAP_CNT         = cnt_t'(CAPACITY);
  localparam word_t NO_OFFSET       = 32'hFFFF_FFFF;
  localparam word_t RANGE_END_RESET = 32'd65536;

  // request codes
  localparam logic [2:0] OP_REQUEST = 3'd0;
  localparam logic [2:0] OP_FREE    = 3'd1;
  localparam logic [2:0] OP_REALLOC = 3'd2;
  localparam logic [2:0] OP_BIGGEST = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FIT    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd3;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd4;

  typedef enum logic [1:0] {
    SC_FIT, SC_USED, SC_NEIGH, SC_BIG
  } scan_kind_t;

  // size of a block, zero when inverted
  function automatic word_t esize(input word_t s, input word_t e);
    return (e >= s) ? (e - s) : '0;
  endfunction

endpackage

// ----- rtl/range_allocator_first_fit_core.sv -----
// ----------------------------------------------------------------------------
// range_allocator_first_fit_core
// first-fit range allocator with coalescing, one block table in a ram with a registered read
// port
// scans: request and take biggest cost one free-region scan, free one used
//   scan and one free scan, a moving reallocate five scans (two over the
//   used region, three over the free region)
// concurrency: one transaction at a time; a new request is taken only in
//   idle, once the previous result is in the output register
// reset: table is [0, range_end) at once, no clearing pass
`include "range_allocator_first_fit_core_macros.svh"

module range_allocator_first_fit_core (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // start_offset[31:0], size_amount[63:32]
  input  logic [2:0]  in_tuser,   // req_type[2:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // offset[31:0], granted_size[63:32],
                                  // free_blocks[70:64], used_blocks[77:71], zero
  output logic [2:0]  out_tuser,  // status[2:0]
  // configuration
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data // range_end
);

  // one-hot sequencer states
  typedef enum logic [29:0] {
    S_IDLE    = 30'b1 << 0,
    S_DISP    = 30'b1 << 1,
    S_SCAN    = 30'b1 << 2,
    S_EVAL    = 30'b1 << 3,
    S_TF_RD   = 30'b1 << 4,
    S_TF_WR   = 30'b1 << 5,
    S_TF_WL   = 30'b1 << 6,
    S_SPL_W1  = 30'b1 << 7,
    S_SPL_W2  = 30'b1 << 8,
    S_REQ_END = 30'b1 << 9,
    S_FR_RD   = 30'b1 << 10,
    S_FR_WR   = 30'b1 << 11,
    S_FM_W    = 30'b1 << 12,
    S_AF_RD   = 30'b1 << 13,
    S_AF_WR   = 30'b1 << 14,
    S_AF_WN   = 30'b1 << 15,
    S_RF_RD1  = 30'b1 << 16,
    S_RF_WR1  = 30'b1 << 17,
    S_RF_RD2  = 30'b1 << 18,
    S_RF_WR2  = 30'b1 << 19,
    S_RA_CHK  = 30'b1 << 20,
    S_RA_DEC  = 30'b1 << 21,
    S_RA_GROW = 30'b1 << 22,
    S_RS_W1   = 30'b1 << 23,
    S_RS_W2   = 30'b1 << 24,
    S_RG_W1   = 30'b1 << 25,
    S_RG_W2   = 30'b1 << 26,
    S_DONE    = 30'b1 << 27,
    S_SPARE0  = 30'b1 << 28,
    S_SPARE1  = 30'b1 << 29
  } state_t;

  // block table: free entries first, then used entries
  raff_pkg::entry_t blk_mem [raff_pkg::CAPACITY];
  raff_pkg::entry_t rd_data_r;
  logic             rd_fresh_r;
  logic             rd_en;
  raff_pkg::idx_t   rd_addr;
  logic             wr_en;
  raff_pkg::idx_t   wr_addr;
  raff_pkg::entry_t wr_data;
  raff_pkg::entry_t rd_ent;

  state_t                 state_r, state_nxt;
  raff_pkg::word_t        range_end_r, range_end_nxt;
  logic                   e0_fresh_r, e0_fresh_nxt;   // entry 0 still holds reset block
  raff_pkg::cnt_t         fc_r, fc_nxt;
  raff_pkg::cnt_t         uc_r, uc_nxt;
  logic [2:0]             op_r, op_nxt;
  raff_pkg::word_t        s_r, s_nxt;
  raff_pkg::word_t        z_r, z_nxt;
  logic                   move_r, move_nxt;           // reallocate by request + free
  raff_pkg::word_t        off_r, off_nxt;
  raff_pkg::word_t        gsz_r, gsz_nxt;
  logic [2:0]             st_r, st_nxt;
  raff_pkg::scan_kind_t   sc_kind_r, sc_kind_nxt;
  raff_pkg::cnt_t         sc_i_r, sc_i_nxt;
  raff_pkg::cnt_t         sc_hi_r, sc_hi_nxt;
  logic                   pv_r, pv_nxt;               // read data in flight for scan
  raff_pkg::idx_t         pc_i_r, pc_i_nxt;
  logic                   hit_r, hit_nxt;
  raff_pkg::idx_t         hit_i_r, hit_i_nxt;
  raff_pkg::word_t        hit_s_r, hit_s_nxt;
  raff_pkg::word_t        hit_e_r, hit_e_nxt;
  raff_pkg::word_t        bs_r, bs_nxt;
  logic                   pb_v_r, pb_v_nxt;           // free block ending at start
  raff_pkg::idx_t         pb_i_r, pb_i_nxt;
  raff_pkg::word_t        pb_s_r, pb_s_nxt;
  raff_pkg::idx_t         idx_r, idx_nxt;
  raff_pkg::word_t        e_r, e_nxt;
  raff_pkg::word_t        bsz_r, bsz_nxt;
  raff_pkg::word_t        diff_r, diff_nxt;
  raff_pkg::word_t        a_s_r, a_s_nxt;
  raff_pkg::word_t        a_e_r, a_e_nxt;
  raff_pkg::idx_t         rf_i_r, rf_i_nxt;
  logic                   out_valid_r, out_valid_nxt;
  raff_pkg::word_t        o_off_r, o_off_nxt;
  raff_pkg::word_t        o_gsz_r, o_gsz_nxt;
  logic [2:0]             o_st_r, o_st_nxt;
  raff_pkg::cnt_t         o_fc_r, o_fc_nxt;
  raff_pkg::cnt_t         o_uc_r, o_uc_nxt;

  logic                   scan_go;
  raff_pkg::scan_kind_t   scan_kind;
  raff_pkg::cnt_t         tot, tot_m1, fc_m1;
  raff_pkg::word_t        rd_size;
  logic                   in_acc;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_st_r;
  assign out_tdata  = {2'b00, o_uc_r, o_fc_r, o_gsz_r, o_off_r};

  assign tot    = fc_r + uc_r;
  assign tot_m1 = tot - raff_pkg::cnt_t'(1);
  assign fc_m1  = fc_r - raff_pkg::cnt_t'(1);

  // an entry 0 not written since reset, clear or a range write reads as the reset block
  assign rd_ent  = rd_fresh_r ? raff_pkg::entry_t'{e: range_end_r, s: '0} : rd_data_r;
  assign rd_size = raff_pkg::esize(rd_ent.s, rd_ent.e);

  // block ram, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r  <= blk_mem[rd_addr];
      rd_fresh_r <= e0_fresh_r && (rd_addr == '0);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    range_end_nxt = range_end_r;
    e0_fresh_nxt  = e0_fresh_r;
    fc_nxt        = fc_r;
    uc_nxt        = uc_r;
    op_nxt        = op_r;
    s_nxt         = s_r;
    z_nxt         = z_r;
    move_nxt      = move_r;
    off_nxt       = off_r;
    gsz_nxt       = gsz_r;
    st_nxt        = st_r;
    sc_kind_nxt   = sc_kind_r;
    sc_i_nxt      = sc_i_r;
    sc_hi_nxt     = sc_hi_r;
    pv_nxt        = pv_r;
    pc_i_nxt      = pc_i_r;
    hit_nxt       = hit_r;
    hit_i_nxt     = hit_i_r;
    hit_s_nxt     = hit_s_r;
    hit_e_nxt     = hit_e_r;
    bs_nxt        = bs_r;
    pb_v_nxt      = pb_v_r;
    pb_i_nxt      = pb_i_r;
    pb_s_nxt      = pb_s_r;
    idx_nxt       = idx_r;
    e_nxt         = e_r;
    bsz_nxt       = bsz_r;
    diff_nxt      = diff_r;
    a_s_nxt       = a_s_r;
    a_e_nxt       = a_e_r;
    rf_i_nxt      = rf_i_r;
    out_valid_nxt = out_valid_r && !out_tready;
    o_off_nxt     = o_off_r;
    o_gsz_nxt     = o_gsz_r;
    o_st_nxt      = o_st_r;
    o_fc_nxt      = o_fc_r;
    o_uc_nxt      = o_uc_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    scan_go       = 1'b0;
    scan_kind     = raff_pkg::SC_FIT;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_tuser;
          s_nxt     = in_tdata[31:0];
          z_nxt     = in_tdata[63:32];
          move_nxt  = 1'b0;
          off_nxt   = raff_pkg::NO_OFFSET;
          gsz_nxt   = '0;
          st_nxt    = raff_pkg::ST_OK;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (op_r)
          raff_pkg::OP_REQUEST: begin
            if (z_r == '0) begin
              st_nxt    = raff_pkg::ST_ZERO_SIZE;
              state_nxt = S_DONE;
            end else begin
              scan_go   = 1'b1;
              scan_kind = raff_pkg::SC_FIT;
            end
          end
          raff_pkg::OP_FREE: begin
            scan_go   = 1'b1;
            scan_kind = raff_pkg::SC_USED;
          end
          raff_pkg::OP_REALLOC: begin
            if (z_r == '0) begin
              st_nxt    = raff_pkg::ST_ZERO_SIZE;
              state_nxt = S_DONE;
            end else begin
              scan_go   = 1'b1;
              scan_kind = raff_pkg::SC_USED;
            end
          end
          raff_pkg::OP_BIGGEST: begin
            scan_go   = 1'b1;
            scan_kind = raff_pkg::SC_BIG;
          end
          raff_pkg::OP_CLEAR: begin
            fc_nxt       = raff_pkg::cnt_t'(1);
            uc_nxt       = '0;
            e0_fresh_nxt = 1'b1;
            state_nxt    = S_DONE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        // issue one read a cycle, check the one that came back
        if (sc_i_r < sc_hi_r) begin
          rd_en    = 1'b1;
          rd_addr  = sc_i_r[raff_pkg::IDX_W-1:0];
          sc_i_nxt = sc_i_r + raff_pkg::cnt_t'(1);
          pv_nxt   = 1'b1;
          pc_i_nxt = sc_i_r[raff_pkg::IDX_W-1:0];
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          case (sc_kind_r)
            raff_pkg::SC_FIT: begin
              if (rd_size >= z_r) begin
                hit_nxt   = 1'b1;
                hit_i_nxt = pc_i_r;
                hit_s_nxt = rd_ent.s;
                hit_e_nxt = rd_ent.e;
                pv_nxt    = 1'b0;
                state_nxt = S_EVAL;
              end
            end
            raff_pkg::SC_USED: begin
              if (rd_ent.s == s_r) begin
                hit_nxt   = 1'b1;
                hit_i_nxt = pc_i_r;
                hit_s_nxt = rd_ent.s;
                hit_e_nxt = rd_ent.e;
                pv_nxt    = 1'b0;
                state_nxt = S_EVAL;
              end
            end
            raff_pkg::SC_NEIGH: begin
              if (!hit_r && (rd_ent.s == e_r)) begin
                hit_nxt   = 1'b1;
                hit_i_nxt = pc_i_r;
                hit_s_nxt = rd_ent.s;
                hit_e_nxt = rd_ent.e;
              end
              if (!pb_v_r && (rd_ent.e == s_r)) begin
                pb_v_nxt = 1'b1;
                pb_i_nxt = pc_i_r;
                pb_s_nxt = rd_ent.s;
              end
            end
            default: begin
              if (rd_size > bs_r) begin
                bs_nxt    = rd_size;
                hit_nxt   = 1'b1;
                hit_i_nxt = pc_i_r;
                hit_s_nxt = rd_ent.s;
                hit_e_nxt = rd_ent.e;
              end
            end
          endcase
        end else if (sc_i_r >= sc_hi_r) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        case (sc_kind_r)
          raff_pkg::SC_FIT: begin
            if (!hit_r) begin
              st_nxt    = raff_pkg::ST_NO_FIT;
              state_nxt = S_DONE;
            end else if (raff_pkg::esize(hit_s_r, hit_e_r) == z_r) begin
              off_nxt   = hit_s_r;
              state_nxt = S_TF_RD;
            end else if (tot >= raff_pkg::CAP_CNT) begin
              st_nxt    = raff_pkg::ST_FULL;
              state_nxt = S_DONE;
            end else begin
              off_nxt   = hit_s_r;
              state_nxt = S_SPL_W1;
            end
          end
          raff_pkg::SC_USED: begin
            if (!hit_r) begin
              st_nxt    = raff_pkg::ST_NOT_ALLOC;
              state_nxt = S_DONE;
            end else begin
              idx_nxt   = hit_i_r;
              e_nxt     = hit_e_r;
              state_nxt = ((op_r == raff_pkg::OP_FREE) || move_r) ? S_FR_RD : S_RA_CHK;
            end
          end
          raff_pkg::SC_NEIGH: begin
            if ((op_r == raff_pkg::OP_FREE) || move_r) begin
              if (!hit_r && !pb_v_r) begin
                a_s_nxt   = s_r;
                a_e_nxt   = e_r;
                state_nxt = S_AF_RD;
              end else begin
                rf_i_nxt  = pb_i_r;
                state_nxt = S_FM_W;
              end
            end else begin
              state_nxt = S_RA_DEC;
            end
          end
          default: begin
            if (!hit_r) begin
              st_nxt    = raff_pkg::ST_NO_FIT;
              state_nxt = S_DONE;
            end else begin
              off_nxt   = hit_s_r;
              gsz_nxt   = bs_r;
              state_nxt = S_TF_RD;
            end
          end
        endcase
      end
      // move free entry hit into the first used slot
      S_TF_RD: begin
        rd_en     = 1'b1;
        rd_addr   = fc_m1[raff_pkg::IDX_W-1:0];
        state_nxt = S_TF_WR;
      end
      S_TF_WR: begin
        wr_en     = 1'b1;
        wr_addr   = hit_i_r;
        wr_data   = rd_ent;
        state_nxt = S_TF_WL;
      end
      S_TF_WL: begin
        wr_en     = 1'b1;
        wr_addr   = fc_m1[raff_pkg::IDX_W-1:0];
        wr_data   = '{e: hit_e_r, s: hit_s_r};
        fc_nxt    = fc_m1;
        uc_nxt    = uc_r + raff_pkg::cnt_t'(1);
        state_nxt = S_REQ_END;
      end
      // split off the low part of the free block
      S_SPL_W1: begin
        wr_en     = 1'b1;
        wr_addr   = hit_i_r;
        wr_data   = '{e: hit_e_r, s: hit_s_r + z_r};
        state_nxt = S_SPL_W2;
      end
      S_SPL_W2: begin
        wr_en     = 1'b1;
        wr_addr   = tot[raff_pkg::IDX_W-1:0];
        wr_data   = '{e: hit_s_r + z_r, s: hit_s_r};
        uc_nxt    = uc_r + raff_pkg::cnt_t'(1);
        state_nxt = S_REQ_END;
      end
      S_REQ_END: begin
        if (move_r) begin
          scan_go   = 1'b1;
          scan_kind = raff_pkg::SC_USED;
        end else begin
          state_nxt = S_DONE;
        end
      end
      // drop the used entry: last used entry fills its slot
      S_FR_RD: begin
        rd_en     = 1'b1;
        rd_addr   = tot_m1[raff_pkg::IDX_W-1:0];
        state_nxt = S_FR_WR;
      end
      S_FR_WR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = rd_ent;
        uc_nxt    = uc_r - raff_pkg::cnt_t'(1);
        scan_go   = 1'b1;
        scan_kind = raff_pkg::SC_NEIGH;
      end
      // merge with neighbors
      S_FM_W: begin
        wr_en = 1'b1;
        if (hit_r && pb_v_r) begin
          wr_addr   = hit_i_r;
          wr_data   = '{e: hit_e_r, s: pb_s_r};
          state_nxt = S_RF_RD1;
        end else if (pb_v_r) begin
          wr_addr   = pb_i_r;
          wr_data   = '{e: e_r, s: pb_s_r};
          state_nxt = S_DONE;
        end else begin
          wr_addr   = hit_i_r;
          wr_data   = '{e: hit_e_r, s: s_r};
          state_nxt = S_DONE;
        end
      end
      // append free entry, first used entry moves to the end
      S_AF_RD: begin
        if (uc_r != '0) begin
          rd_en     = 1'b1;
          rd_addr   = fc_r[raff_pkg::IDX_W-1:0];
          state_nxt = S_AF_WR;
        end else begin
          state_nxt = S_AF_WN;
        end
      end
      S_AF_WR: begin
        wr_en     = 1'b1;
        wr_addr   = tot[raff_pkg::IDX_W-1:0];
        wr_data   = rd_ent;
        state_nxt = S_AF_WN;
      end
      S_AF_WN: begin
        wr_en     = 1'b1;
        wr_addr   = fc_r[raff_pkg::IDX_W-1:0];
        wr_data   = '{e: a_e_r, s: a_s_r};
        fc_nxt    = fc_r + raff_pkg::cnt_t'(1);
        state_nxt = S_DONE;
      end
      // discard free entry rf_i
      S_RF_RD1: begin
        rd_en     = 1'b1;
        rd_addr   = fc_m1[raff_pkg::IDX_W-1:0];
        state_nxt = S_RF_WR1;
      end
      S_RF_WR1: begin
        wr_en     = 1'b1;
        wr_addr   = rf_i_r;
        wr_data   = rd_ent;
        state_nxt = S_RF_RD2;
      end
      S_RF_RD2: begin
        rd_en     = 1'b1;
        rd_addr   = tot_m1[raff_pkg::IDX_W-1:0];
        state_nxt = S_RF_WR2;
      end
      S_RF_WR2: begin
        wr_en     = 1'b1;
        wr_addr   = fc_m1[raff_pkg::IDX_W-1:0];
        wr_data   = rd_ent;
        fc_nxt    = fc_m1;
        state_nxt = S_DONE;
      end
      // reallocate
      S_RA_CHK: begin
        bsz_nxt = e_r - s_r;
        if ((e_r - s_r) == z_r) begin
          off_nxt   = s_r;
          state_nxt = S_DONE;
        end else begin
          scan_go   = 1'b1;
          scan_kind = raff_pkg::SC_NEIGH;
        end
      end
      S_RA_DEC: begin
        if (bsz_r > z_r) begin
          if (!hit_r && (tot >= raff_pkg::CAP_CNT)) begin
            st_nxt    = raff_pkg::ST_FULL;
            state_nxt = S_DONE;
          end else begin
            off_nxt   = s_r;
            a_s_nxt   = s_r + z_r;
            a_e_nxt   = e_r;
            state_nxt = S_RS_W1;
          end
        end else begin
          diff_nxt  = z_r - bsz_r;
          state_nxt = S_RA_GROW;
        end
      end
      S_RA_GROW: begin
        if (hit_r && (raff_pkg::esize(hit_s_r, hit_e_r) >= diff_r)) begin
          off_nxt   = s_r;
          a_s_nxt   = e_r + diff_r;
          state_nxt = S_RG_W1;
        end else begin
          move_nxt  = 1'b1;
          scan_go   = 1'b1;
          scan_kind = raff_pkg::SC_FIT;
        end
      end
      S_RS_W1: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = '{e: a_s_r, s: s_r};
        state_nxt = hit_r ? S_RS_W2 : S_AF_RD;
      end
      S_RS_W2: begin
        wr_en     = 1'b1;
        wr_addr   = hit_i_r;
        wr_data   = '{e: hit_e_r, s: a_s_r};
        state_nxt = S_DONE;
      end
      S_RG_W1: begin
        wr_en     = 1'b1;
        wr_addr   = hit_i_r;
        wr_data   = '{e: hit_e_r, s: a_s_r};
        state_nxt = S_RG_W2;
      end
      S_RG_W2: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = '{e: a_s_r, s: s_r};
        if (hit_e_r == a_s_r) begin
          // following free block used up
          rf_i_nxt  = hit_i_r;
          state_nxt = S_RF_RD1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          o_off_nxt     = off_r;
          o_gsz_nxt     = gsz_r;
          o_st_nxt      = st_r;
          o_fc_nxt      = fc_r;
          o_uc_nxt      = uc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (scan_go) begin
      sc_kind_nxt = scan_kind;
      sc_i_nxt    = (scan_kind == raff_pkg::SC_USED) ? fc_r : '0;
      sc_hi_nxt   = (scan_kind == raff_pkg::SC_USED) ? tot : fc_r;
      hit_nxt     = 1'b0;
      pb_v_nxt    = 1'b0;
      bs_nxt      = '0;
      pv_nxt      = 1'b0;
      state_nxt   = S_SCAN;
    end

    if (wr_en && (wr_addr == '0)) begin
      e0_fresh_nxt = 1'b0;
    end

    // register write resets the table
    if (cfg_wr_en) begin
      range_end_nxt = cfg_wr_data;
      fc_nxt        = raff_pkg::cnt_t'(1);
      uc_nxt        = '0;
      e0_fresh_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      range_end_r <= raff_pkg::RANGE_END_RESET;
      e0_fresh_r  <= 1'b1;
      fc_r        <= raff_pkg::cnt_t'(1);
      uc_r        <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      move_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      range_end_r <= range_end_nxt;
      e0_fresh_r  <= e0_fresh_nxt;
      fc_r        <= fc_nxt;
      uc_r        <= uc_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
      move_r      <= move_nxt;
    end
  end

  // operation payload and scratch
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    s_r       <= s_nxt;
    z_r       <= z_nxt;
    off_r     <= off_nxt;
    gsz_r     <= gsz_nxt;
    st_r      <= st_nxt;
    sc_kind_r <= sc_kind_nxt;
    sc_i_r    <= sc_i_nxt;
    sc_hi_r   <= sc_hi_nxt;
    pc_i_r    <= pc_i_nxt;
    hit_r     <= hit_nxt;
    hit_i_r   <= hit_i_nxt;
    hit_s_r   <= hit_s_nxt;
    hit_e_r   <= hit_e_nxt;
    bs_r      <= bs_nxt;
    pb_v_r    <= pb_v_nxt;
    pb_i_r    <= pb_i_nxt;
    pb_s_r    <= pb_s_nxt;
    idx_r     <= idx_nxt;
    e_r       <= e_nxt;
    bsz_r     <= bsz_nxt;
    diff_r    <= diff_nxt;
    a_s_r     <= a_s_nxt;
    a_e_r     <= a_e_nxt;
    rf_i_r    <= rf_i_nxt;
    o_off_r   <= o_off_nxt;
    o_gsz_r   <= o_gsz_nxt;
    o_st_r    <= o_st_nxt;
    o_fc_r    <= o_fc_nxt;
    o_uc_r    <= o_uc_nxt;
  end

  // table occupancy never exceeds the ram depth
  `RAFF_ASSERT_NOW(a_occupancy, 1'b1, (fc_r + uc_r) <= raff_pkg::CAP_CNT, "table overflow")
  // the ram is never written while no transaction is in progress
  `RAFF_ASSERT_NOW(a_idle_no_write, state_r == S_IDLE, !wr_en, "write while idle")
  // scan data in flight only comes from a scan read
  `RAFF_ASSERT_NOW(a_scan_pipe, pv_r, $past(rd_en) && $past(state_r == S_SCAN),
                   "scan data without scan read")
  // removing a free entry needs one
  `RAFF_ASSERT_NOW(a_remove_nonempty, state_r == S_RF_RD1, fc_r != '0,
                   "remove from empty free region")

endmodule
